// ===== src/dual_axis_stepper_mount_controller_defines.svh =====
// Assertion macros for the stepper mount controller.
// Used by the top level; no other dependencies.
`ifndef DUAL_AXIS_STEPPER_MOUNT_CONTROLLER_DEFINES_SVH
`define DUAL_AXIS_STEPPER_MOUNT_CONTROLLER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define DASM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define DASM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/dasm_pkg.sv =====
// Package for the stepper mount controller: word types, constants.
// No dependencies.
package dasm_pkg;

    localparam int AXIS_COUNT = 2;
    localparam int AXIS_W     = 1;

    typedef struct packed {
        logic        mode;
        logic [7:0]  lead_char;
        logic [7:0]  cmd_letter;
        logic [7:0]  axis_char;
        logic [23:0] arg_value;
        logic [7:0]  arg_head;
    } in_word_t;

    typedef struct packed {
        logic        is_error;
        logic [1:0]  error_code;
        logic [2:0]  digit_count;
        logic [23:0] reply_data;
    } out_word_t;

    localparam logic [1:0] ERR_BAD_CMD   = 2'd0;
    localparam logic [1:0] ERR_RUNNING   = 2'd1;
    localparam logic [1:0] ERR_BAD_START = 2'd2;

    localparam logic [1:0] CFG_FAST_STEP = 2'd0;
    localparam logic [1:0] CFG_SPR       = 2'd1;
    localparam logic [1:0] CFG_WORM      = 2'd2;
    localparam logic [1:0] CFG_TICK_FREQ = 2'd3;

    localparam int F_RUN   = 0;
    localparam int F_TRACK = 4;
    localparam int F_BACK  = 5;
    localparam int F_FAST  = 6;
    localparam int F_INIT  = 8;

    localparam logic [31:0] POS_RESET0 = 32'h0080_0000;
    localparam logic [31:0] POS_RESET1 = 32'h0080_0000 + 32'd216000;
    localparam logic [23:0] DIV_RESET  = 24'd25;
    localparam logic [15:0] FEAT_RESET = 16'h6007;
    localparam logic [23:0] DATA_D     = 24'd100;
    localparam logic [23:0] DATA_E     = 24'h040302;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;

endpackage

// ===== src/dual_axis_stepper_mount_controller.sv =====
// Top level of the two-axis stepper mount controller.
// Depends on dasm_pkg and the defines header.
//
//  channel | ports            | direction | payload
//  input   | s_valid/s_ready  | in        | dasm_pkg::in_word_t
//  result  | m_valid/m_ready  | out       | dasm_pkg::out_word_t
//  config  | cfg_we/idx/data  | in        | 24-bit register data
//
// One word a cycle while not stalled: input register, combinational axis
// update and reply decode, then a result register. Ticks give no result word.
// s_ready is low only while the result register is full and stalled.
// Reset is synchronous, active low, and restores every axis register.
`include "dual_axis_stepper_mount_controller_defines.svh"
module dual_axis_stepper_mount_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dasm_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dasm_pkg::out_word_t  m_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [23:0]          cfg_data
);
    import dasm_pkg::*;

    // Configuration registers.
    logic [7:0]  fast_reg;
    logic [23:0] spr_reg, worm_reg, freq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_reg <= 8'd128;
            spr_reg  <= 24'd864000;
            worm_reg <= 24'd14400;
            freq_reg <= 24'd1000;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FAST_STEP: fast_reg <= cfg_data[7:0];
                CFG_SPR:       spr_reg  <= cfg_data;
                CFG_WORM:      worm_reg <= cfg_data;
                default:       freq_reg <= cfg_data;
            endcase
        end
    end

    // Input register.
    logic     in_valid_reg;
    in_word_t in_reg;
    logic     out_valid_reg;
    out_word_t out_reg;
    logic     stall;

    assign stall   = out_valid_reg && !m_ready;
    assign s_ready = !stall;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (!stall) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall && s_valid) begin
            in_reg <= s_data;
        end
    end

    // Per-axis state.
    logic [23:0] cnt_reg  [AXIS_COUNT];
    logic [23:0] div_reg  [AXIS_COUNT];
    logic [11:0] flg_reg  [AXIS_COUNT];
    logic [31:0] pos_reg  [AXIS_COUNT];
    logic [31:0] tgt_reg  [AXIS_COUNT];
    logic [23:0] inc_reg  [AXIS_COUNT];
    logic        incp_reg [AXIS_COUNT];
    logic        tgtp_reg [AXIS_COUNT];
    logic [31:0] brk_reg  [AXIS_COUNT];
    logic [15:0] feat_reg [AXIS_COUNT];
    logic [31:0] abs_reg  [AXIS_COUNT];
    logic [31:0] home_reg [AXIS_COUNT];

    // Selected axis's next values.
    logic [23:0] cnt_next, div_next, inc_next;
    logic [11:0] flg_next;
    logic [31:0] pos_next, tgt_next, brk_next, abs_next, home_next;
    logic        incp_next, tgtp_next;
    logic [15:0] feat_next;
    logic        ax_ok;
    logic [AXIS_W-1:0] ax;
    logic        fire, busy;
    out_word_t   res;
    logic        res_valid;

    // Move helper values.
    logic        mv, mv_down;
    logic [31:0] mv_n, mv_dist, fs32, mv_abs;

    assign busy = in_valid_reg && !stall;

    always_comb begin
        ax_ok = (in_reg.axis_char == CH_ONE) || (in_reg.axis_char == CH_TWO);
        ax    = AXIS_W'(in_reg.axis_char[0] ? 1'b0 : 1'b1);
        if (ax_ok && (32'(ax) >= AXIS_COUNT)) ax_ok = 1'b0;
        fs32  = {24'd0, fast_reg};
    end

    always_comb begin
        cnt_next  = cnt_reg[ax];
        div_next  = div_reg[ax];
        flg_next  = flg_reg[ax];
        pos_next  = pos_reg[ax];
        tgt_next  = tgt_reg[ax];
        inc_next  = inc_reg[ax];
        incp_next = incp_reg[ax];
        tgtp_next = tgtp_reg[ax];
        brk_next  = brk_reg[ax];
        feat_next = feat_reg[ax];
        abs_next  = abs_reg[ax];
        home_next = home_reg[ax];
        res       = '0;
        res_valid = 1'b0;
        mv        = 1'b0;
        mv_down   = 1'b0;
        mv_n      = 32'd0;
        mv_dist   = 32'd0;
        mv_abs    = 32'd0;
        fire      = 1'b0;

        if (in_reg.mode) begin
            // Timer tick: divider, then track or goto step.
            if (ax_ok) begin
                cnt_next = cnt_reg[ax] + 24'd1;
                fire = !(cnt_next < div_reg[ax]);
                if (fire) begin
                    cnt_next = 24'd0;
                    if (flg_reg[ax][F_RUN]) begin
                        if (flg_reg[ax][F_TRACK]) begin
                            mv = 1'b1;
                            mv_down = flg_reg[ax][F_BACK];
                            mv_n = flg_reg[ax][F_FAST] ? fs32 : 32'd1;
                        end else if (pos_reg[ax] > tgt_reg[ax]) begin
                            mv_dist = pos_reg[ax] - tgt_reg[ax];
                            mv = 1'b1;
                            mv_down = 1'b1;
                            mv_n = (mv_dist <= fs32) ? mv_dist : fs32;
                        end else if (pos_reg[ax] < tgt_reg[ax]) begin
                            mv_dist = tgt_reg[ax] - pos_reg[ax];
                            mv = 1'b1;
                            mv_n = (mv_dist <= fs32) ? mv_dist : fs32;
                        end else begin
                            flg_next[F_RUN] = 1'b0;
                        end
                    end
                end
            end
            if (mv) begin
                mv_abs = mv_down ? abs_reg[ax] - mv_n : abs_reg[ax] + mv_n;
                if (mv_abs[31] != abs_reg[ax][31])
                    home_next = pos_reg[ax] - abs_reg[ax];
                abs_next = mv_abs;
                pos_next = mv_down ? pos_reg[ax] - mv_n : pos_reg[ax] + mv_n;
            end
        end else begin
            // Command decode with one reply word.
            res_valid = 1'b1;
            if (in_reg.lead_char != CH_COLON) begin
                res.is_error = 1'b1;
                res.error_code = ERR_BAD_START;
            end else if (!ax_ok) begin
                res.is_error = 1'b1;
                res.error_code = ERR_BAD_CMD;
            end else begin
                case (in_reg.cmd_letter)
                    "B": flg_next = 12'd0;
                    "D": begin res.digit_count = 3'd6; res.reply_data = DATA_D; end
                    "E": pos_next = {8'd0, in_reg.arg_value};
                    "F": flg_next[F_INIT] = 1'b1;
                    "G": begin
                        if (flg_reg[ax][F_RUN]) begin
                            res.is_error = 1'b1;
                            res.error_code = ERR_RUNNING;
                        end else begin
                            flg_next[F_BACK] = in_reg.arg_value[0];
                            case (in_reg.arg_value[7:4])
                                4'd0: begin flg_next[F_TRACK] = 1'b0; flg_next[F_FAST] = 1'b1; end
                                4'd1: begin flg_next[F_TRACK] = 1'b1; flg_next[F_FAST] = 1'b0; end
                                4'd2: begin flg_next[F_TRACK] = 1'b0; flg_next[F_FAST] = 1'b0; end
                                4'd3: begin flg_next[F_TRACK] = 1'b1; flg_next[F_FAST] = 1'b1; end
                                default: ;
                            endcase
                        end
                    end
                    "H": begin
                        div_next = 24'd1;
                        inc_next = in_reg.arg_value;
                        incp_next = 1'b1;
                        tgtp_next = 1'b0;
                    end
                    "I": div_next = in_reg.arg_value;
                    "J": begin
                        if (flg_reg[ax][F_TRACK]) begin
                            flg_next[F_RUN] = 1'b1;
                        end else if (incp_reg[ax]) begin
                            tgt_next = flg_reg[ax][F_BACK]
                                ? pos_reg[ax] - {8'd0, inc_reg[ax]}
                                : pos_reg[ax] + {8'd0, inc_reg[ax]};
                            incp_next = 1'b0;
                            flg_next[F_RUN] = 1'b1;
                        end else if (tgtp_reg[ax]) begin
                            tgtp_next = 1'b0;
                            flg_next[F_RUN] = 1'b1;
                        end
                    end
                    "K", "L": flg_next[F_RUN] = 1'b0;
                    "M": brk_next = flg_reg[ax][F_BACK]
                        ? pos_reg[ax] - {8'd0, in_reg.arg_value}
                        : pos_reg[ax] + {8'd0, in_reg.arg_value};
                    "O", "P", "T", "V": ;
                    "S": begin
                        if (flg_reg[ax][F_RUN]) begin
                            res.is_error = 1'b1;
                            res.error_code = ERR_RUNNING;
                        end else begin
                            div_next = 24'd1;
                            tgt_next = {8'd0, in_reg.arg_value};
                            incp_next = 1'b0;
                            tgtp_next = 1'b1;
                        end
                    end
                    "U": brk_next = {8'd0, in_reg.arg_value};
                    "W": begin
                        case (in_reg.arg_value)
                            24'h000000: feat_next[4] = 1'b1;
                            24'h000001: feat_next[4] = 1'b0;
                            24'h000002: feat_next[5] = 1'b1;
                            24'h000003: feat_next[5] = 1'b0;
                            24'h000004, 24'h000005, 24'h000006, 24'h000106: ;
                            24'h000008: home_next = abs_reg[ax][31] ? 32'd0 : 32'hFFFF_FFFF;
                            default: begin
                                res.is_error = 1'b1;
                                res.error_code = ERR_BAD_CMD;
                            end
                        endcase
                    end
                    "a": begin res.digit_count = 3'd6; res.reply_data = spr_reg; end
                    "b": begin res.digit_count = 3'd6; res.reply_data = freq_reg; end
                    "c", "m": begin
                        res.digit_count = 3'd6; res.reply_data = brk_reg[ax][23:0];
                    end
                    "e": begin res.digit_count = 3'd6; res.reply_data = DATA_E; end
                    "f": begin
                        res.digit_count = 3'd3; res.reply_data = {12'd0, flg_reg[ax]};
                    end
                    "g": begin
                        res.digit_count = 3'd2; res.reply_data = {16'd0, fast_reg};
                    end
                    "h": begin
                        res.digit_count = 3'd6; res.reply_data = tgt_reg[ax][23:0];
                    end
                    "i": begin res.digit_count = 3'd6; res.reply_data = div_reg[ax]; end
                    "j": begin
                        res.digit_count = 3'd6; res.reply_data = pos_reg[ax][23:0];
                    end
                    "k": if (in_reg.arg_head == CH_ONE) inc_next = 24'd0;
                    "q": begin
                        if (in_reg.arg_value == 24'd0) begin
                            res.digit_count = 3'd6;
                            res.reply_data = home_reg[ax][23:0];
                        end else if (in_reg.arg_value == 24'd1) begin
                            res.digit_count = 3'd6;
                            res.reply_data = {8'd0, feat_reg[ax]};
                        end else begin
                            res.is_error = 1'b1;
                            res.error_code = ERR_BAD_CMD;
                        end
                    end
                    "s": begin res.digit_count = 3'd6; res.reply_data = worm_reg; end
                    default: begin
                        res.is_error = 1'b1;
                        res.error_code = ERR_BAD_CMD;
                    end
                endcase
            end
        end
    end

    // Write back the selected axis.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXIS_COUNT; i++) begin
                cnt_reg[i]  <= 24'd0;
                div_reg[i]  <= DIV_RESET;
                flg_reg[i]  <= 12'd0;
                pos_reg[i]  <= (i[0]) ? POS_RESET1 : POS_RESET0;
                tgt_reg[i]  <= 32'd0;
                inc_reg[i]  <= 24'd0;
                incp_reg[i] <= 1'b0;
                tgtp_reg[i] <= 1'b0;
                brk_reg[i]  <= 32'd0;
                feat_reg[i] <= FEAT_RESET;
                abs_reg[i]  <= 32'd0;
                home_reg[i] <= 32'd0;
            end
        end else if (busy && ax_ok) begin
            cnt_reg[ax]  <= cnt_next;
            div_reg[ax]  <= div_next;
            flg_reg[ax]  <= flg_next;
            pos_reg[ax]  <= pos_next;
            tgt_reg[ax]  <= tgt_next;
            inc_reg[ax]  <= inc_next;
            incp_reg[ax] <= incp_next;
            tgtp_reg[ax] <= tgtp_next;
            brk_reg[ax]  <= brk_next;
            feat_reg[ax] <= feat_next;
            abs_reg[ax]  <= abs_next;
            home_reg[ax] <= home_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!stall) begin
            out_valid_reg <= in_valid_reg && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            out_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `DASM_ASSERT_IMPL(a_err_no_digits, aclk, aresetn, m_valid && m_data.is_error, m_data.digit_count == 3'd0)
    `DASM_ASSERT_IMPL(a_ok_code_zero, aclk, aresetn, m_valid && !m_data.is_error, m_data.error_code == ERR_BAD_CMD)
    `DASM_ASSERT_NEXT(a_tick_no_result, aclk, aresetn, busy && in_reg.mode, !m_valid)
    `DASM_ASSERT_NEXT(a_stall_holds, aclk, aresetn, stall, m_valid)

endmodule
